// ===== rtl/a64dpi_pkg.sv =====
`timescale 1ns / 1ps

package a64dpi_pkg;

    // Result status codes
    localparam logic [1:0] STAT_EXEC   = 2'd0;
    localparam logic [1:0] STAT_CLASS  = 2'd1;
    localparam logic [1:0] STAT_UNUSED = 2'd2;

    // Instruction class (bits 28:26) and op groups (bits 25:23)
    localparam logic [2:0] CLASS_DPI   = 3'b100;
    localparam logic [2:0] OPI_ADDSUB  = 3'b010;
    localparam logic [2:0] OPI_MOVWIDE = 3'b101;

    // Wide move opcodes
    localparam logic [1:0] OPC_MOVN = 2'b00;
    localparam logic [1:0] OPC_RSVD = 2'b01;
    localparam logic [1:0] OPC_MOVZ = 2'b10;
    localparam logic [1:0] OPC_MOVK = 2'b11;

    // Register numbering
    localparam int         NUM_GPR  = 31;
    localparam logic [4:0] REG_ZR   = 5'd31;

    // Halfword placement for wide moves
    localparam logic [15:0] HALF_MASK = 16'hFFFF;
    localparam int          HALF_BITS = 16;

    typedef logic [63:0] xword_t;

endpackage

// ===== rtl/a64_data_processing_immediate_top.sv =====
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------
// input    in_valid / in_ready   instr_word[31:0]
// output   out_valid / out_ready status, reg_written, dest_index, write_value,
//                                flags_set, nzcv
//
// One instruction per cycle unless the result stalls; a word passes through
// the decode register (register file read on entry), then the result register.
// The register file has one write port and two registered read ports; a write
// and a read of the same entry in one cycle forward the new value.
// Reset clears all valid bits, so every general register and the flags read zero.
// A stalled result holds the decode register; input ready drops only then.

module a64_data_processing_immediate_top
    import a64dpi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] instr_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        reg_written,
    output logic [4:0]  dest_index,
    output logic [63:0] write_value,
    output logic        flags_set,
    output logic [3:0]  nzcv
);

    // Register file storage
    xword_t              gpr_mem [NUM_GPR];
    logic [NUM_GPR-1:0]  ent_vld_reg;

    // Decode stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] instr_reg;
    xword_t      rn_data_reg;
    xword_t      rd_data_reg;
    logic        rn_vld_reg;
    logic        rd_vld_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  status_reg;
    logic        reg_written_reg;
    logic [4:0]  dest_index_reg;
    xword_t      write_value_reg;
    logic        flags_set_reg;
    logic [3:0]  flags_reg;

    // Handshake control
    logic        load;
    logic        advance;

    // Execute signals
    logic        wide;
    logic [1:0]  opc;
    logic [2:0]  opi;
    logic [4:0]  rd_idx;
    logic [4:0]  rn_idx;
    xword_t      wmask;
    xword_t      src_a;
    xword_t      src_d;
    xword_t      imm12;
    xword_t      addend;
    logic [32:0] sum_lo;
    logic [32:0] sum_hi;
    xword_t      sum_raw;
    xword_t      arith_res;
    logic        top_a;
    logic        top_b;
    logic        top_r;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic [5:0]  half_sh;
    xword_t      placed;
    xword_t      keep;
    logic [1:0]  stat_next;
    xword_t      value_next;
    logic        done_next;
    logic        setf_next;
    logic        wr_en;
    logic [3:0]  flags_next;

    // Advance a word into the result register when that register is free or its result is taken
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign load     = in_valid && in_ready;

    assign s1_valid_next  = load || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    // Decode fields of the held word
    assign wide   = instr_reg[31];
    assign opc    = instr_reg[30:29];
    assign opi    = instr_reg[25:23];
    assign rd_idx = instr_reg[4:0];
    assign rn_idx = instr_reg[9:5];
    assign wmask  = wide ? '1 : {32'd0, 32'hFFFF_FFFF};

    // Zero register and never-written entries read as zero
    always_comb
    begin
        src_a = (rn_idx != REG_ZR && rn_vld_reg) ? rn_data_reg : '0;
        src_a = src_a & wmask;
        src_d = (rd_idx != REG_ZR && rd_vld_reg) ? rd_data_reg : '0;
        src_d = src_d & wmask;
    end

    // Add or subtract the immediate, split at bit 32 for the narrow carry
    always_comb
    begin
        imm12   = instr_reg[22] ? {40'd0, instr_reg[21:10], 12'd0}
                                : {52'd0, instr_reg[21:10]};
        addend  = opc[1] ? ~imm12 : imm12;
        sum_lo  = {1'b0, src_a[31:0]} + {1'b0, addend[31:0]} + {32'd0, opc[1]};
        sum_hi  = {1'b0, src_a[63:32]} + {1'b0, addend[63:32]} + {32'd0, sum_lo[32]};
        sum_raw = {sum_hi[31:0], sum_lo[31:0]};
        arith_res = sum_raw & wmask;

        top_a  = wide ? src_a[63] : src_a[31];
        top_b  = wide ? imm12[63] : imm12[31];
        top_r  = wide ? arith_res[63] : arith_res[31];
        flag_n = top_r;
        flag_z = (arith_res == '0);
        flag_c = wide ? sum_hi[32] : sum_lo[32];
        if (opc[1])
        begin
            flag_v = (top_a != top_b) && (top_r != top_a);
        end
        else
        begin
            flag_v = (top_a == top_b) && (top_r != top_a);
        end
    end

    // Place the 16-bit immediate at its halfword
    always_comb
    begin
        half_sh = 6'(instr_reg[22:21] * HALF_BITS);
        placed  = {48'd0, instr_reg[20:5]} << half_sh;
        keep    = ~({48'd0, HALF_MASK} << half_sh);
    end

    // Select the result of the held word
    always_comb
    begin
        stat_next  = STAT_EXEC;
        value_next = '0;
        done_next  = 1'b0;
        setf_next  = 1'b0;
        if (instr_reg[28:26] != CLASS_DPI)
        begin
            stat_next = STAT_CLASS;
        end
        else if (opi == OPI_ADDSUB)
        begin
            value_next = arith_res;
            done_next  = 1'b1;
            setf_next  = opc[0];
        end
        else if (opi == OPI_MOVWIDE)
        begin
            if (opc == OPC_RSVD || (!wide && instr_reg[22]))
            begin
                stat_next = STAT_UNUSED;
            end
            else
            begin
                done_next = 1'b1;
                case (opc)
                    OPC_MOVN: value_next = ~placed & wmask;
                    OPC_MOVZ: value_next = placed & wmask;
                    OPC_MOVK: value_next = ((src_d & keep) | placed) & wmask;
                    default:  value_next = '0;
                endcase
            end
        end
        else
        begin
            stat_next = STAT_UNUSED;
        end
    end

    assign wr_en      = advance && done_next && (rd_idx != REG_ZR);
    assign flags_next = (advance && setf_next) ? {flag_n, flag_z, flag_c, flag_v}
                                               : flags_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            ent_vld_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
            if (wr_en)
            begin
                ent_vld_reg[rd_idx] <= 1'b1;
            end
        end
    end

    // Register file: write back, read both sources of the incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            gpr_mem[rd_idx] <= value_next;
        end
        if (load)
        begin
            instr_reg <= instr_word;
            if (wr_en && rd_idx == instr_word[9:5])
            begin
                rn_data_reg <= value_next;
                rn_vld_reg  <= 1'b1;
            end
            else
            begin
                rn_data_reg <= gpr_mem[instr_word[9:5]];
                rn_vld_reg  <= ent_vld_reg[instr_word[9:5]];
            end
            if (wr_en && rd_idx == instr_word[4:0])
            begin
                rd_data_reg <= value_next;
                rd_vld_reg  <= 1'b1;
            end
            else
            begin
                rd_data_reg <= gpr_mem[instr_word[4:0]];
                rd_vld_reg  <= ent_vld_reg[instr_word[4:0]];
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg      <= stat_next;
            reg_written_reg <= done_next && (rd_idx != REG_ZR);
            dest_index_reg  <= rd_idx;
            write_value_reg <= value_next;
            flags_set_reg   <= setf_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign reg_written = reg_written_reg;
    assign dest_index  = dest_index_reg;
    assign write_value = write_value_reg;
    assign flags_set   = flags_set_reg;
    assign nzcv        = flags_reg;

`ifndef NO_ASSERTIONS
    // The zero register is never stored
    a_no_zr_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> rd_idx != REG_ZR)
        else $error("write to zero register");

    // Flags move only when a flag-setting word advances
    a_flags_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (flags_reg != $past(flags_reg)) |-> $past(advance && setf_next))
        else $error("flags changed without ADDS or SUBS");

    // A word that did not execute leaves no state change behind
    a_noexec_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != STAT_EXEC |-> !reg_written_reg && !flags_set_reg)
        else $error("non-executed word reports an update");

    // Input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

    // A new result appears only after a decoded word advanced
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a decoded word");
`endif

endmodule

// ===== sim/a64_data_processing_immediate_top_test.sv =====
`timescale 1ns / 1ps

module a64_data_processing_immediate_top_test;
    import a64dpi_pkg::*;

    // Add/sub immediate opcodes: bit 1 selects subtract, bit 0 sets flags
    localparam logic [1:0] OPC_ADD  = 2'b00;
    localparam logic [1:0] OPC_ADDS = 2'b01;
    localparam logic [1:0] OPC_SUB  = 2'b10;
    localparam logic [1:0] OPC_SUBS = 2'b11;

    localparam int RANDOM_WORDS = 850;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [63:0] write_value;
        logic        flags_set;
        logic [3:0]  nzcv;
    } dpi_result_t;

    typedef struct packed {
        logic        drain;
        logic [31:0] word;
    } queued_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] instr_word = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [63:0] write_value;
    logic        flags_set;
    logic [3:0]  nzcv;

    // Architectural state as the predictor sees it
    xword_t      gpr_shadow [0:NUM_GPR-1];
    logic [3:0]  nzcv_shadow;

    queued_word_t pending_words [$];
    dpi_result_t  expected_results [$];

    int  words_taken = 0;
    int  errors = 0;
    int  stall_cycles = 0;
    logic calm;

    a64_data_processing_immediate_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .instr_word  (instr_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .reg_written (reg_written),
        .dest_index  (dest_index),
        .write_value (write_value),
        .flags_set   (flags_set),
        .nzcv        (nzcv)
    );

    always #10 clk = ~clk;

    // No idling on either side during this window of words
    assign calm = (words_taken >= 500) && (words_taken < 650);

    function automatic xword_t read_gpr(logic [4:0] idx, logic wide);
        if (idx == REG_ZR)
            return '0;
        return wide ? gpr_shadow[idx] : {32'b0, gpr_shadow[idx][31:0]};
    endfunction

    // Execute one word against the shadow state and return its result
    function automatic dpi_result_t execute_word(logic [31:0] w);
        dpi_result_t res;
        logic        wide;
        logic [1:0]  opc;
        logic [4:0]  rd;
        xword_t      wmask;
        int          top;
        xword_t      imm;
        xword_t      a;
        xword_t      r;
        xword_t      placed;
        int          sh;
        logic        sub;
        logic        sa;
        logic        sb;
        logic        sr;
        logic        c;
        logic        v;
        logic        written;

        wide    = w[31];
        opc     = w[30:29];
        rd      = w[4:0];
        wmask   = wide ? {64{1'b1}} : 64'h0000_0000_FFFF_FFFF;
        top     = wide ? 63 : 31;
        written = 1'b0;
        res     = '0;
        res.status     = STAT_EXEC;
        res.dest_index = rd;

        if (w[28:26] != CLASS_DPI)
        begin
            res.status = STAT_CLASS;
        end
        else if (w[25:23] == OPI_ADDSUB)
        begin
            imm = {52'b0, w[21:10]};
            if (w[22])
                imm = imm << 12;
            a   = read_gpr(w[9:5], wide);
            sub = opc[1];
            r   = (sub ? a - imm : a + imm) & wmask;
            res.write_value = r;
            written = 1'b1;
            if (opc[0])
            begin
                sa = a[top];
                sb = imm[top];
                sr = r[top];
                if (sub)
                begin
                    c = (a >= imm);
                    v = (sa != sb) && (sr != sa);
                end
                else
                begin
                    c = (r < a);
                    v = (sa == sb) && (sr != sa);
                end
                nzcv_shadow   = {sr, (r == '0), c, v};
                res.flags_set = 1'b1;
            end
        end
        else if (w[25:23] == OPI_MOVWIDE)
        begin
            sh = int'(w[22:21]) * HALF_BITS;
            if (opc == OPC_RSVD || (!wide && w[22]))
            begin
                res.status = STAT_UNUSED;
            end
            else
            begin
                placed = {48'b0, w[20:5]} << sh;
                if (opc == OPC_MOVN)
                    res.write_value = ~placed & wmask;
                else if (opc == OPC_MOVZ)
                    res.write_value = placed & wmask;
                else
                    res.write_value = ((read_gpr(rd, wide) & ~({48'b0, HALF_MASK} << sh))
                                       | placed) & wmask;
                written = 1'b1;
            end
        end
        else
        begin
            res.status = STAT_UNUSED;
        end

        // Drop writes to the zero register
        if (written && rd != REG_ZR)
        begin
            gpr_shadow[rd]  = res.write_value;
            res.reg_written = 1'b1;
        end
        res.nzcv = nzcv_shadow;
        return res;
    endfunction

    function automatic logic [31:0] enc_addsub(logic sf, logic [1:0] opc, logic sh,
                                               logic [11:0] imm, logic [4:0] rn,
                                               logic [4:0] rd);
        return {sf, opc, CLASS_DPI, OPI_ADDSUB, sh, imm, rn, rd};
    endfunction

    function automatic logic [31:0] enc_movwide(logic sf, logic [1:0] opc, logic [1:0] hw,
                                                logic [15:0] imm, logic [4:0] rd);
        return {sf, opc, CLASS_DPI, OPI_MOVWIDE, hw, imm, rd};
    endfunction

    // Right class, but an op group that decodes to nothing
    function automatic logic [31:0] enc_unused_group();
        logic [2:0]  opi;
        logic [31:0] w;
        do
            opi = 3'($urandom_range(7));
        while (opi == OPI_ADDSUB || opi == OPI_MOVWIDE);
        w = $urandom;
        w[28:26] = CLASS_DPI;
        w[25:23] = opi;
        return w;
    endfunction

    // Favor a few registers so results feed later words
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 70)
            return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    function automatic logic [11:0] pick_imm12();
        case ($urandom_range(9))
            0: return 12'h000;
            1: return 12'hFFF;
            2: return 12'h001;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_imm16();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_word(logic [31:0] w, logic drain);
        queued_word_t item;
        item.word  = w;
        item.drain = drain;
        pending_words.push_back(item);
    endtask

    // Driver: present the next word, predict it once taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            instr_word <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(execute_word(instr_word));
                words_taken <= words_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 16) &&
                    !(pending_words[0].drain && expected_results.size() != 0))
                begin
                    instr_word <= pending_words[0].word;
                    in_valid   <= 1'b1;
                    void'(pending_words.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        dpi_result_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, status);
                        errors++;
                    end
                    if (reg_written !== exp_res.reg_written)
                    begin
                        $error("reg_written: expected %0d, got %0d",
                               exp_res.reg_written, reg_written);
                        errors++;
                    end
                    if (dest_index !== exp_res.dest_index)
                    begin
                        $error("dest_index: expected %0d, got %0d",
                               exp_res.dest_index, dest_index);
                        errors++;
                    end
                    if (write_value !== exp_res.write_value)
                    begin
                        $error("write_value: expected %h, got %h",
                               exp_res.write_value, write_value);
                        errors++;
                    end
                    if (flags_set !== exp_res.flags_set)
                    begin
                        $error("flags_set: expected %0d, got %0d",
                               exp_res.flags_set, flags_set);
                        errors++;
                    end
                    if (nzcv !== exp_res.nzcv)
                    begin
                        $error("nzcv: expected %b, got %b", exp_res.nzcv, nzcv);
                        errors++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 16);
        end
    end

    // Watchdog: end the run if no word moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int          i;
        int          pick;
        logic [31:0] w;

        for (i = 0; i < NUM_GPR; i++)
            gpr_shadow[i] = '0;
        nzcv_shadow = '0;

        // Directed words: extremes, every operation, edge cases
        queue_word(enc_movwide(1'b1, OPC_MOVZ, 2'd3, 16'hFFFF, 5'd0), 1'b0);
        queue_word(enc_movwide(1'b1, OPC_MOVK, 2'd0, 16'h1234, 5'd0), 1'b0);
        queue_word(enc_movwide(1'b1, OPC_MOVN, 2'd0, 16'h0000, 5'd1), 1'b0);
        queue_word(enc_movwide(1'b0, OPC_MOVN, 2'd1, 16'hFFFF, 5'd2), 1'b0);
        // 32-bit wide move at an upper halfword is unallocated
        queue_word(enc_movwide(1'b0, OPC_MOVZ, 2'd2, 16'h5555, 5'd3), 1'b0);
        queue_word(enc_movwide(1'b0, OPC_MOVK, 2'd3, 16'hAAAA, 5'd3), 1'b0);
        queue_word(enc_movwide(1'b1, OPC_RSVD, 2'd1, 16'hABCD, 5'd3), 1'b0);
        // Carry and zero from all-ones plus one, borrow from zero minus one
        queue_word(enc_addsub(1'b1, OPC_ADDS, 1'b0, 12'h001, 5'd1, 5'd4), 1'b0);
        queue_word(enc_addsub(1'b1, OPC_SUBS, 1'b0, 12'h001, REG_ZR, 5'd5), 1'b0);
        // Signed overflow at bit 31
        queue_word(enc_movwide(1'b0, OPC_MOVZ, 2'd0, 16'hFFFF, 5'd7), 1'b0);
        queue_word(enc_movwide(1'b0, OPC_MOVK, 2'd1, 16'h7FFF, 5'd7), 1'b0);
        queue_word(enc_addsub(1'b0, OPC_ADDS, 1'b0, 12'h001, 5'd7, 5'd6), 1'b0);
        queue_word(enc_movwide(1'b0, OPC_MOVZ, 2'd1, 16'h8000, 5'd9), 1'b0);
        queue_word(enc_addsub(1'b0, OPC_SUBS, 1'b0, 12'h001, 5'd9, 5'd8), 1'b0);
        // Signed overflow at bit 63 with a shifted immediate
        queue_word(enc_movwide(1'b1, OPC_MOVN, 2'd3, 16'h8000, 5'd10), 1'b0);
        queue_word(enc_addsub(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd10, 5'd11), 1'b0);
        // 32-bit results zero-extend, then a 64-bit subtract of a shifted immediate
        queue_word(enc_addsub(1'b0, OPC_ADD, 1'b0, 12'h000, 5'd1, 5'd12), 1'b0);
        queue_word(enc_addsub(1'b1, OPC_SUB, 1'b1, 12'hFFF, 5'd0, 5'd13), 1'b0);
        // Zero register as destination: value shown, write dropped; then a zero result
        queue_word(enc_addsub(1'b1, OPC_ADDS, 1'b1, 12'hFFF, 5'd1, REG_ZR), 1'b0);
        queue_word(enc_movwide(1'b1, OPC_MOVK, 2'd2, 16'hABCD, REG_ZR), 1'b0);
        queue_word(enc_addsub(1'b0, OPC_SUBS, 1'b0, 12'h000, 5'd15, 5'd15), 1'b0);
        // Wrong class and unused op groups
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(enc_unused_group(), 1'b0);
        queue_word(enc_unused_group(), 1'b0);

        // Random words, mostly well-formed; hold off for a full drain twice
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                w = enc_addsub(1'($urandom), 2'($urandom), 1'($urandom), pick_imm12(),
                               pick_reg(), pick_reg());
            else if (pick < 75)
                w = enc_movwide(1'($urandom), 2'($urandom), 2'($urandom), pick_imm16(),
                                pick_reg());
            else if (pick < 85)
                w = enc_unused_group();
            else
                w = $urandom;
            queue_word(w, (i == 0) || (i == 400));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all words to go in and every result to come back
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
